[hw/rtl/ffca_pkg.sv]
`timescale 1ns / 1ps

package ffca_pkg;

  // Atlas geometry
  localparam int CHUNK_SHIFT     = 4;
  localparam int CHUNK_PIXELS    = 1 << CHUNK_SHIFT;
  localparam int CHUNKS_PER_SIDE = 32;

  localparam int IDX_W = $clog2(CHUNKS_PER_SIDE);
  localparam int CNT_W = $clog2(CHUNKS_PER_SIDE + 1);

  // Port widths
  localparam int PX_W  = 10;
  localparam int OFF_W = 9;

  // Rounded chunk count of a 10-bit pixel size
  localparam int CH_W  = PX_W + 1 - CHUNK_SHIFT;
  localparam int SUM_W = CH_W + CNT_W;

  typedef logic [CHUNKS_PER_SIDE-1:0] col_t;

  // Bitmap access: read column addr, optionally OR mask into it
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    col_t             mask;
  } map_req_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] x_off;
    logic [OFF_W-1:0] y_off;
  } res_t;

endpackage

[hw/rtl/ffca_bitmap.sv]
`timescale 1ns / 1ps

// Used-chunk bitmap, one word per chunk column. Columns never written read as free.
module ffca_bitmap (
  input  logic              clk,
  input  logic              rst_n,
  input  ffca_pkg::map_req_t req,
  output ffca_pkg::col_t     rdata
);

  ffca_pkg::col_t                        col_r [ffca_pkg::CHUNKS_PER_SIDE];
  logic [ffca_pkg::CHUNKS_PER_SIDE-1:0] vld_r;

  assign rdata = vld_r[req.addr] ? col_r[req.addr] : '0;

  always_ff @(posedge clk) begin
    if (req.we) begin
      col_r[req.addr] <= rdata | req.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

endmodule

[hw/rtl/ffca_seq.sv]
`timescale 1ns / 1ps

// Search sequencer: per column origin x, OR the window columns into acc_r,
// then slide the row window down acc_r one row a cycle; mark on a hit.
module ffca_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [ffca_pkg::PX_W-1:0]        in_width_px,
  input  logic [ffca_pkg::PX_W-1:0]        in_height_px,
  output logic                             in_stall,
  input  logic                             res_ready,
  output logic                             res_valid,
  output ffca_pkg::res_t                   res,
  output ffca_pkg::map_req_t               map_req,
  input  ffca_pkg::col_t                   map_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_SCAN,
    S_MARK,
    S_DONE
  } state_t;

  localparam int N     = ffca_pkg::CHUNKS_PER_SIDE;
  localparam int SUM_W = ffca_pkg::SUM_W;
  localparam int CH_W  = ffca_pkg::CH_W;
  localparam int CNT_W = ffca_pkg::CNT_W;
  localparam int IDX_W = ffca_pkg::IDX_W;
  localparam int OFF_W = ffca_pkg::OFF_W;
  localparam int RND_W = ffca_pkg::PX_W + 1;

  state_t             state_r, state_nxt;
  logic [CH_W-1:0]    cw_r, cw_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [CNT_W-1:0]   x_r, x_nxt;
  logic [CNT_W-1:0]   y_r, y_nxt;
  logic [CNT_W-1:0]   col_i_r, col_i_nxt;
  ffca_pkg::col_t     acc_r, acc_nxt;
  ffca_pkg::col_t     mask_r, mask_nxt;
  logic               found_r, found_nxt;

  logic [CH_W-1:0]    in_cw, in_ch;
  logic [RND_W-1:0]   w_rnd, h_rnd;
  logic [CNT_W-1:0]   addr_full;
  ffca_pkg::col_t     win_mask;
  logic               x_more, y_more, cols_done;
  logic [SUM_W-1:0]   y_end;

  // Round pixels up to chunks
  assign w_rnd = RND_W'(in_width_px)  + RND_W'(ffca_pkg::CHUNK_PIXELS - 1);
  assign h_rnd = RND_W'(in_height_px) + RND_W'(ffca_pkg::CHUNK_PIXELS - 1);
  assign in_cw = w_rnd[RND_W-1:ffca_pkg::CHUNK_SHIFT];
  assign in_ch = h_rnd[RND_W-1:ffca_pkg::CHUNK_SHIFT];

  assign x_more    = (SUM_W'(x_r) + SUM_W'(cw_r) + SUM_W'(1)) <= SUM_W'(N);
  assign y_more    = (SUM_W'(y_r) + SUM_W'(ch_r) + SUM_W'(1)) <= SUM_W'(N);
  assign cols_done = SUM_W'(col_i_r) == SUM_W'(cw_r);
  assign addr_full = x_r + col_i_r;
  assign y_end     = SUM_W'(y_r) + SUM_W'(ch_r);

  always_comb begin
    for (int b = 0; b < N; b++) begin
      win_mask[b] = (SUM_W'(b) >= SUM_W'(y_r)) && (SUM_W'(b) < y_end);
    end
  end

  assign map_req.we   = (state_r == S_MARK) && !cols_done;
  assign map_req.addr = addr_full[IDX_W-1:0];
  assign map_req.mask = mask_r;

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.found = found_r;
  assign res.x_off = found_r ? OFF_W'({x_r, {ffca_pkg::CHUNK_SHIFT{1'b0}}}) : '0;
  assign res.y_off = found_r ? OFF_W'({y_r, {ffca_pkg::CHUNK_SHIFT{1'b0}}}) : '0;

  always_comb begin
    state_nxt = state_r;
    cw_nxt    = cw_r;
    ch_nxt    = ch_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    col_i_nxt = col_i_r;
    acc_nxt   = acc_r;
    mask_nxt  = mask_r;
    found_nxt = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cw_nxt    = in_cw;
          ch_nxt    = in_ch;
          x_nxt     = '0;
          y_nxt     = '0;
          col_i_nxt = '0;
          acc_nxt   = '0;
          found_nxt = 1'b0;
          if (in_cw > CH_W'(N) || in_ch > CH_W'(N)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ACCUM;
          end
        end
      end
      S_ACCUM: begin
        if (cols_done) begin
          y_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          acc_nxt   = acc_r | map_rdata;
          col_i_nxt = col_i_r + CNT_W'(1);
        end
      end
      S_SCAN: begin
        if ((acc_r & win_mask) == '0) begin
          mask_nxt  = win_mask;
          col_i_nxt = '0;
          found_nxt = 1'b1;
          state_nxt = S_MARK;
        end else if (y_more) begin
          y_nxt = y_r + CNT_W'(1);
        end else if (x_more) begin
          x_nxt     = x_r + CNT_W'(1);
          acc_nxt   = '0;
          col_i_nxt = '0;
          state_nxt = S_ACCUM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        if (cols_done) begin
          state_nxt = S_DONE;
        end else begin
          col_i_nxt = col_i_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cw_r    <= cw_nxt;
    ch_r    <= ch_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    col_i_r <= col_i_nxt;
    acc_r   <= acc_nxt;
    mask_r  <= mask_nxt;
    found_r <= found_nxt;
  end

endmodule

[hw/rtl/first_fit_2d_chunk_allocator.sv]
`timescale 1ns / 1ps

// Channel | Prefix | Handshake    | Fields                          | Item
// in      | in_    | valid, stall | width_px, height_px             | frame size in pixels
// out     | out_   | valid, stall | found, x_offset_px, y_offset_px | origin or not-found
//
// Steps: per column origin x, OR the window columns into an accumulator, then
//   slide the row window down it; on a hit, mark the window columns, then pass
//   through a done state before the output register loads.
// Reset: rst_n (synchronous) frees every chunk at once via per-column valid bits.
// Stalls: in_stall is high from accept until the result enters the output register,
//   where a waiting result does not block the next accept.
module first_fit_2d_chunk_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ffca_pkg::PX_W-1:0]  in_width_px,
  input  logic [ffca_pkg::PX_W-1:0]  in_height_px,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [ffca_pkg::OFF_W-1:0] out_x_offset_px,
  output logic [ffca_pkg::OFF_W-1:0] out_y_offset_px
);

  ffca_pkg::map_req_t map_req;
  ffca_pkg::col_t     map_rdata;
  ffca_pkg::res_t     res;
  ffca_pkg::res_t     out_res_r;
  logic               res_valid;
  logic               res_ready;
  logic               out_valid_r;

  // Shared column store: read one column a cycle, OR-in the window when marking
  ffca_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata)
  );

  ffca_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_width_px  (in_width_px),
    .in_height_px (in_height_px),
    .in_stall     (in_stall),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res),
    .map_req      (map_req),
    .map_rdata    (map_rdata)
  );

  // Output slot frees when empty or when the current item is taken this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_x_offset_px = out_res_r.x_off;
  assign out_y_offset_px = out_res_r.y_off;

endmodule

[test/tb_first_fit_2d_chunk_allocator.sv]
`timescale 1ns / 1ps

// Testbench for the first-fit 2D chunk allocator.
// The predictor keeps its own copy of the chunk bitmap and replays the
// column-major first-fit search for every accepted item. Its results wait in a
// queue until the checker compares them with the block's output.
// Both sides idle in random bursts, except in stretches of the random test and in the tests after it.
module tb_first_fit_2d_chunk_allocator;

  localparam int WATCHDOG_LIMIT = 20000; // idle cycles
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 230;
  localparam int FILL_CAP       = 1100;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [ffca_pkg::PX_W-1:0]  in_width_px;
  logic [ffca_pkg::PX_W-1:0]  in_height_px;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_found;
  logic [ffca_pkg::OFF_W-1:0] out_x_offset_px;
  logic [ffca_pkg::OFF_W-1:0] out_y_offset_px;

  // Predictor state: one word per chunk column, bit y = chunk row y
  ffca_pkg::col_t chunk_map [ffca_pkg::CHUNKS_PER_SIDE];
  ffca_pkg::res_t expected_placements [$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit idle_on      = 1'b1;

  first_fit_2d_chunk_allocator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_width_px     (in_width_px),
    .in_height_px    (in_height_px),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_x_offset_px (out_x_offset_px),
    .out_y_offset_px (out_y_offset_px)
  );

  always #5 clk = ~clk;

  // Predictor: rounds the frame to chunks, then scans origins with x outer,
  // y inner for the first all-free window. Covers rows y .. y+ch-1 only.
  function automatic ffca_pkg::res_t predict_placement(input int w_px, input int h_px);
    ffca_pkg::res_t r;
    int             cw;
    int             ch;
    int             x;
    int             y;
    int             i;
    bit             hit;
    bit             clear;
    logic [63:0]    wide;
    ffca_pkg::col_t rows;
    r   = '0;
    hit = 1'b0;
    cw  = (w_px + ffca_pkg::CHUNK_PIXELS - 1) / ffca_pkg::CHUNK_PIXELS;
    ch  = (h_px + ffca_pkg::CHUNK_PIXELS - 1) / ffca_pkg::CHUNK_PIXELS;
    if (cw > ffca_pkg::CHUNKS_PER_SIDE || ch > ffca_pkg::CHUNKS_PER_SIDE) return r;
    for (x = 0; x + cw <= ffca_pkg::CHUNKS_PER_SIDE && !hit; x++) begin
      for (y = 0; y + ch <= ffca_pkg::CHUNKS_PER_SIDE && !hit; y++) begin
        wide  = ((64'd1 << ch) - 64'd1) << y;
        rows  = wide[ffca_pkg::CHUNKS_PER_SIDE-1:0];
        clear = 1'b1;
        for (i = x; i < x + cw; i++)
          if ((chunk_map[i] & rows) != '0) clear = 1'b0;
        if (clear) begin
          for (i = x; i < x + cw; i++) chunk_map[i] |= rows;
          hit     = 1'b1;
          r.found = 1'b1;
          r.x_off = ffca_pkg::OFF_W'(x * ffca_pkg::CHUNK_PIXELS);
          r.y_off = ffca_pkg::OFF_W'(y * ffca_pkg::CHUNK_PIXELS);
        end
      end
    end
    return r;
  endfunction

  function automatic int free_chunks();
    int n;
    n = 0;
    foreach (chunk_map[c]) n += ffca_pkg::CHUNKS_PER_SIDE - $countones(chunk_map[c]);
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Sends one frame size; returns at the edge where it was accepted
  task automatic send_frame(input int w_px, input int h_px);
    int             gap;
    ffca_pkg::res_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_width_px  <= ffca_pkg::PX_W'(w_px);
    in_height_px <= ffca_pkg::PX_W'(h_px);
    do @(posedge clk); while (in_stall);
    want = predict_placement(w_px, h_px);
    expected_placements = {expected_placements, want};
  endtask

  // Holds off the sender until every expected placement has come back
  task automatic await_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_placements.size() != 0);
  endtask

  // Result checker
  always @(posedge clk) begin
    ffca_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_placements.size() == 0) begin
        report_mismatch("unexpected result, found", out_found, 0);
      end else begin
        want = expected_placements.pop_front();
        if (out_found !== want.found)
          report_mismatch("found", out_found, want.found);
        if (out_x_offset_px !== want.x_off)
          report_mismatch("x_offset_px", out_x_offset_px, want.x_off);
        if (out_y_offset_px !== want.y_off)
          report_mismatch("y_offset_px", out_y_offset_px, want.y_off);
      end
    end
  end

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty frames fit at the origin and mark nothing
  task automatic test_zero_size();
    send_frame(0, 0);
    send_frame(0, 37);
    send_frame(200, 0);
    await_drain();
  endtask

  // Single chunks, including partial-chunk sizes that round up
  task automatic test_single_chunks();
    send_frame(1, 1);
    send_frame(16, 16);
    send_frame(15, 9);
    await_drain();
  endtask

  // A 1x3 then a 2x1 window: the 2x1 must land right under the 1x3,
  // which fails if the tall window claims one row too many
  task automatic test_row_bound();
    send_frame(16, 48);
    send_frame(32, 16);
    send_frame(1, 1);
    await_drain();
  endtask

  // Full-height column and full-width row windows
  task automatic test_full_span();
    send_frame(16, 512);
    send_frame(512, 16);
    send_frame(17, 511);
    await_drain();
  endtask

  // Sizes over 32 chunks in either direction, every input bit set, and a full 32x32 frame
  task automatic test_oversize();
    send_frame(513, 16);
    send_frame(16, 513);
    send_frame(1023, 1023);
    send_frame(1023, 1);
    send_frame(512, 512);
    await_drain();
  endtask

  // Mostly small frames so the bitmap fills gradually; the rest is noise
  task automatic test_random_frames();
    int n;
    int sel;
    int w;
    int h;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on <= (n % 60) < 45; // some stretches run without idling
      if (n == RANDOM_ITEMS / 2) await_drain();
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        w = $urandom_range(1, 48);
        h = $urandom_range(1, 48);
      end else if (sel < 65) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 128);
      end else if (sel < 75) begin
        w = $urandom_range(1, 256);
        h = $urandom_range(1, 32);
      end else if (sel < 82) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 1023);
        h = (w == 0) ? $urandom_range(0, 1023) : 0;
      end else if (sel < 92) begin
        w = $urandom_range(0, 1023);
        h = $urandom_range(0, 1023);
      end else begin
        w = $urandom_range(481, 528);
        h = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) begin
          sel = w;
          w   = h;
          h   = sel;
        end
      end
      send_frame(w, h);
    end
    await_drain();
  endtask

  // Single chunks until the atlas is full
  task automatic test_fill_atlas();
    int n;
    for (n = 0; n < FILL_CAP && free_chunks() != 0; n++)
      send_frame($urandom_range(1, 16), $urandom_range(1, 16));
    await_drain();
  endtask

  // Full atlas, back to back with no idling on either side
  task automatic test_atlas_full();
    idle_on <= 1'b0;
    send_frame(16, 16);
    send_frame(0, 0);
    send_frame(1, 1);
    send_frame(512, 512);
    send_frame(0, 512);
    send_frame(1, 513);
    send_frame($urandom_range(1, 64), $urandom_range(1, 64));
    send_frame($urandom_range(1, 64), $urandom_range(1, 64));
    await_drain();
  endtask

  initial begin
    foreach (chunk_map[c]) chunk_map[c] = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_width_px  <= '0;
    in_height_px <= '0;
    out_stall    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_size();
    test_single_chunks();
    test_row_bound();
    test_full_span();
    test_oversize();
    test_random_frames();
    test_fill_atlas();
    test_atlas_full();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
